// File: design/tsb_pkg.sv
// Shared types and constants for the text screen blitter.
`timescale 1ns / 1ps
package tsb_pkg;
  localparam int ScreenRows = 25;
  localparam int ScreenCols = 80;
  localparam int Depth      = ScreenRows * ScreenCols;
  localparam int AddrW      = $clog2(Depth);
  localparam logic [7:0] SpaceChar = 8'h20;

  typedef enum logic [2:0] {
    KIND_PLOT  = 3'd0,
    KIND_HFILL = 3'd1,
    KIND_VFILL = 3'd2,
    KIND_COPY  = 3'd3,
    KIND_MOVE  = 3'd4,
    KIND_READ  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic [6:0] run_length;
    logic [4:0] block_height;
    logic [6:0] block_width;
    logic [4:0] dest_row;
    logic [6:0] dest_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cell_value;
    logic [2:0] done_kind;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_SNAP, ST_DRAIN, ST_PUT, ST_READ, ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_step;  // clear sweep step
    logic load;      // take input word
    logic fill_step;
    logic snap_step;
    logic put_step;
    logic rd_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fill_last;
    logic blk_last;
    logic zero_size;
  } sts_t;
endpackage

// File: design/tsb_ctrl.sv
// Command sequencer for the text screen blitter.
`timescale 1ns / 1ps
module tsb_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  tsb_pkg::kind_e           in_kind_i,
  input  logic                     out_busy_i,
  input  tsb_pkg::sts_t            sts_i,
  output tsb_pkg::cmd_t            cmd_o,
  output logic                     in_ready_o
);
  import tsb_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_kind_i)
            KIND_PLOT, KIND_HFILL, KIND_VFILL: state_d = ST_FILL;
            KIND_COPY, KIND_MOVE:              state_d = ST_SNAP;
            KIND_READ:                         state_d = ST_READ;
            default:                           state_d = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        if (sts_i.zero_size) state_d = ST_DONE;
        else begin
          cmd_o.fill_step = 1'b1;
          if (sts_i.fill_last) state_d = ST_DONE;
        end
      end
      ST_SNAP: begin
        if (sts_i.zero_size) state_d = ST_DONE;
        else begin
          cmd_o.snap_step = 1'b1;
          if (sts_i.blk_last) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_PUT;
      ST_PUT: begin
        cmd_o.put_step = 1'b1;
        if (sts_i.blk_last) state_d = ST_DONE;
      end
      ST_READ: begin
        cmd_o.rd_step = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// File: design/tsb_datapath.sv
// Screen store, snapshot store, address counters and result register.
`timescale 1ns / 1ps
module tsb_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsb_pkg::in_word_t  in_word_i,
  input  tsb_pkg::cmd_t      cmd_i,
  output tsb_pkg::sts_t      sts_o,
  output tsb_pkg::out_word_t out_word_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import tsb_pkg::*;

  logic [7:0] screen_mem [Depth];
  logic [7:0] snap_mem   [Depth];

  in_word_t       w_q;
  logic [AddrW:0] clr_q;
  logic [6:0]     k_q;       // fill index / block column
  logic [4:0]     i_q;       // block row
  logic [7:0]     rd_q;
  logic [7:0]     snap_rd_q;
  logic           put_src_ok_q;
  logic [7:0]     cell_q;
  logic           out_valid_q;
  out_word_t      out_q;

  logic [7:0] fr, pr;   // 8 bits: row + 127 fits
  logic [7:0] fc, pc;
  logic [7:0] sr, sc;
  logic       f_on, s_on, p_on;
  logic [AddrW-1:0] f_addr, s_addr, p_addr, c_addr;

  function automatic logic [AddrW-1:0] addr_of(input logic [7:0] r, input logic [7:0] c);
    logic [AddrW+7:0] t;
    t = (AddrW+8)'(r) * (AddrW+8)'(ScreenCols) + (AddrW+8)'(c);
    return t[AddrW-1:0];
  endfunction

  always_comb begin
    fr = {3'b0, w_q.row};
    fc = {1'b0, w_q.col};
    if (w_q.kind == KIND_HFILL) fc = {1'b0, w_q.col} + {1'b0, k_q};
    if (w_q.kind == KIND_VFILL) fr = {3'b0, w_q.row} + {1'b0, k_q};
    f_on = (fr < 8'(ScreenRows)) && (fc < 8'(ScreenCols));
    sr = {3'b0, w_q.row} + {3'b0, i_q};
    sc = {1'b0, w_q.col} + {1'b0, k_q};
    s_on = (sr < 8'(ScreenRows)) && (sc < 8'(ScreenCols));
    pr = {3'b0, w_q.dest_row} + {3'b0, i_q};
    pc = {1'b0, w_q.dest_col} + {1'b0, k_q};
    p_on = (pr < 8'(ScreenRows)) && (pc < 8'(ScreenCols));
    f_addr = addr_of(fr, fc);
    s_addr = addr_of(sr, sc);
    p_addr = addr_of(pr, pc);
    c_addr = clr_q[AddrW-1:0];
  end

  assign sts_o.clr_last  = (clr_q == (AddrW+1)'(Depth - 1));
  assign sts_o.fill_last = (w_q.kind == KIND_PLOT) || (k_q == w_q.run_length - 7'd1);
  assign sts_o.blk_last  = (k_q == w_q.block_width - 7'd1) && (i_q == w_q.block_height - 5'd1);
  assign sts_o.zero_size = ((w_q.kind == KIND_HFILL || w_q.kind == KIND_VFILL)
                            && w_q.run_length == '0)
                         || ((w_q.kind == KIND_COPY || w_q.kind == KIND_MOVE)
                            && (w_q.block_width == '0 || w_q.block_height == '0));

  // The write lands in the cycle after the put step: stage the address.
  logic             put_q;
  logic [AddrW-1:0] put_addr_q;
  logic             put_on_q;

  // Screen store: one port shared by the sweeps, plus a one-address read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) screen_mem[c_addr] <= SpaceChar;
    else if (cmd_i.fill_step && f_on) screen_mem[f_addr] <= w_q.ch;
    else if (cmd_i.snap_step && s_on && w_q.kind == KIND_MOVE) screen_mem[s_addr] <= SpaceChar;
    else if (put_q && put_on_q) screen_mem[put_addr_q] <= put_src_ok_q ? snap_rd_q : SpaceChar;
    rd_q <= screen_mem[(cmd_i.snap_step) ? s_addr : f_addr];
  end

  // Snapshot store: written in the cycle after the screen read.
  logic             snap_wr_q, snap_on_q;
  logic [AddrW-1:0] snap_addr_q;
  always_ff @(posedge clk_i) begin
    snap_addr_q <= s_addr;
    snap_on_q   <= s_on;
    if (snap_wr_q && snap_on_q) snap_mem[snap_addr_q] <= rd_q;
    snap_rd_q    <= snap_mem[s_addr];
    put_src_ok_q <= s_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_wr_q   <= 1'b0;
      clr_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      put_q       <= 1'b0;
    end else begin
      snap_wr_q <= cmd_i.snap_step;
      put_q     <= cmd_i.put_step;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        k_q <= '0;
        i_q <= '0;
      end else if (cmd_i.fill_step) begin
        k_q <= k_q + 7'd1;
      end else if (cmd_i.snap_step || cmd_i.put_step) begin
        if (k_q == w_q.block_width - 7'd1) begin
          k_q <= '0;
          i_q <= (cmd_i.snap_step && sts_o.blk_last) ? 5'd0 : i_q + 5'd1;
        end else k_q <= k_q + 7'd1;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    put_addr_q <= p_addr;
    put_on_q   <= p_on;
    if (cmd_i.load) w_q <= in_word_i;
    if (cmd_i.load) cell_q <= '0;
    if (cmd_i.rd_step) cell_q <= f_on ? screen_mem[f_addr] : SpaceChar;
    if (cmd_i.out_load) begin
      out_q.cell_value <= cell_q;
      out_q.done_kind  <= w_q.kind;
    end
  end

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;
endmodule

// File: design/text_screen_blitter.sv
// Top level of the text screen blitter.
`timescale 1ns / 1ps
// One command word in, one result word out. After reset the screen is swept
// to spaces before the first word is taken. Copy and move go one cell a
// cycle through the single screen store port, first into the snapshot
// store, then onto the destination.
module text_screen_blitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsb_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsb_pkg::out_word_t out_data_o
);
  import tsb_pkg::*;
  cmd_t cmd;
  sts_t sts;

  tsb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i,
    .in_kind_i (kind_e'(in_data_i.kind)),
    .out_busy_i(out_valid_o && !out_ready_i),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o
  );

  tsb_datapath u_dp (
    .clk_i, .rst_ni, .in_word_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .out_word_o(out_data_o), .out_valid_o, .out_ready_i
  );

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.fill_step, cmd.snap_step, cmd.put_step, cmd.rd_step}))
    else $error("several datapath steps at once");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.snap_step && !cmd.put_step)
    else $error("word taken mid-command");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && !out_ready_i))
    else $error("result overwritten");
endmodule

// File: dv/text_screen_blitter_tb.sv
// Self-checking testbench for the text screen blitter: directed commands, then random traffic.
`timescale 1ns / 1ps
module text_screen_blitter_tb;
  import tsb_pkg::*;

  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam int NumDirected = 24;
  localparam int NumRandom   = 112;
  localparam int InBits      = $bits(in_word_t);

  typedef struct {
    in_word_t  cmd;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic [7:0] screen_mem [ScreenRows][ScreenCols];
  logic [7:0] snap_mem   [ScreenRows][ScreenCols];

  stim_row_t cmd_queue[$];
  stim_row_t cur_row;
  out_word_t result_queue[$];
  stim_row_t dir_tab [NumDirected];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int words_done = 0;
  int kind_seen [8];

  text_screen_blitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #100000000;
    $display("Timeout with %0d results outstanding", result_queue.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit on_screen(int r, int c);
    return r < ScreenRows && c < ScreenCols;
  endfunction

  function automatic void put_cell(int r, int c, logic [7:0] v);
    if (on_screen(r, c)) screen_mem[r][c] = v;
  endfunction

  function automatic void blit(in_word_t w, bit blank);
    int r, c;
    for (int i = 0; i < w.block_height; i++) begin
      for (int j = 0; j < w.block_width; j++) begin
        r = w.row + i;
        c = w.col + j;
        if (on_screen(r, c)) begin
          snap_mem[r][c] = screen_mem[r][c];
          if (blank) screen_mem[r][c] = SpaceChar;
        end
      end
    end
    for (int i = 0; i < w.block_height; i++) begin
      for (int j = 0; j < w.block_width; j++) begin
        r = w.row + i;
        c = w.col + j;
        put_cell(w.dest_row + i, w.dest_col + j, on_screen(r, c) ? snap_mem[r][c] : SpaceChar);
      end
    end
  endfunction

  function automatic out_word_t screen_update(in_word_t w);
    out_word_t res;
    res.cell_value = '0;
    res.done_kind  = w.kind;
    case (w.kind)
      KIND_PLOT:  put_cell(w.row, w.col, w.ch);
      KIND_HFILL: for (int k = 0; k < w.run_length; k++) put_cell(w.row, w.col + k, w.ch);
      KIND_VFILL: for (int k = 0; k < w.run_length; k++) put_cell(w.row + k, w.col, w.ch);
      KIND_COPY:  blit(w, 1'b0);
      KIND_MOVE:  blit(w, 1'b1);
      KIND_READ:  res.cell_value = on_screen(w.row, w.col) ? screen_mem[w.row][w.col] : SpaceChar;
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk(logic [2:0] k, int r, int c, int ch, int run, int bh, int bw,
                                   int dr, int dc, bit typed = 1'b0, int cv = 0);
    stim_row_t s;
    s.cmd = '{kind: k, row: 5'(r), col: 7'(c), ch: 8'(ch), run_length: 7'(run),
              block_height: 5'(bh), block_width: 7'(bw), dest_row: 5'(dr), dest_col: 7'(dc)};
    s.typed = typed;
    s.want  = '{cell_value: 8'(cv), done_kind: k};
    return s;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t s;
    int sel;
    s.typed = 1'b0;
    s.want  = '0;
    s.cmd = InBits'({$urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 20) s.cmd.kind = KIND_PLOT;
    else if (sel < 33) s.cmd.kind = KIND_HFILL;
    else if (sel < 46) s.cmd.kind = KIND_VFILL;
    else if (sel < 61) s.cmd.kind = KIND_COPY;
    else if (sel < 74) s.cmd.kind = KIND_MOVE;
    else if (sel < 95) s.cmd.kind = KIND_READ;
    else s.cmd.kind = sel[0] ? KIND_SPARE7 : KIND_SPARE6;
    if ($urandom_range(99) < 85) begin
      s.cmd.row = 5'($urandom_range(ScreenRows - 1));
      s.cmd.col = 7'($urandom_range(ScreenCols - 1));
    end
    if ($urandom_range(99) < 85) begin
      s.cmd.dest_row = 5'($urandom_range(ScreenRows - 1));
      s.cmd.dest_col = 7'($urandom_range(ScreenCols - 1));
    end
    if ($urandom_range(99) < 85) s.cmd.run_length = 7'($urandom_range(20));
    if ($urandom_range(99) < 92) begin
      s.cmd.block_height = 5'($urandom_range(4));
      s.cmd.block_width  = 7'($urandom_range(8));
    end
    return s;
  endfunction

  // sender: hold the word until taken, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        out_word_t res;
        res = screen_update(cur_row.cmd);
        if (cur_row.typed) begin
          if (res.cell_value !== cur_row.want.cell_value)
            report_mismatch("typed cell_value", int'(res.cell_value),
                            int'(cur_row.want.cell_value));
          if (res.done_kind !== cur_row.want.done_kind)
            report_mismatch("typed done_kind", int'(res.done_kind),
                            int'(cur_row.want.done_kind));
        end
        result_queue.push_back(res);
        kind_seen[cur_row.cmd.kind]++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_row  = cmd_queue.pop_front();
          in_data  <= cur_row.cmd;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off when asked, else random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data), 0);
      end else begin
        out_word_t want;
        want = result_queue.pop_front();
        if (out_data.cell_value !== want.cell_value)
          report_mismatch("cell_value", int'(out_data.cell_value), int'(want.cell_value));
        if (out_data.done_kind !== want.done_kind)
          report_mismatch("done_kind", int'(out_data.done_kind), int'(want.done_kind));
        words_done++;
      end
    end
  end

  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || result_queue.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int send_pct [4] = '{0, 85, 0, 16};
    int recv_pct [4] = '{0, 0, 85, 16};
    for (int r = 0; r < ScreenRows; r++)
      for (int c = 0; c < ScreenCols; c++) screen_mem[r][c] = SpaceChar;
    dir_tab = '{
      mk(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 0, 1'b1, SpaceChar),
      mk(KIND_PLOT,  0, 0, "H", 0, 0, 0, 0, 0, 1'b1, 0),
      mk(KIND_PLOT,  0, 1, "i", 0, 0, 0, 0, 0),
      mk(KIND_PLOT,  0, 2, "!", 0, 0, 0, 0, 0),
      mk(KIND_READ,  0, 1, 0, 0, 0, 0, 0, 0),
      mk(KIND_HFILL, 24, 70, 8'hFF, 127, 31, 127, 31, 127),
      mk(KIND_VFILL, 20, 79, 8'h00, 127, 0, 0, 0, 0),
      mk(KIND_HFILL, 3, 5, "x", 0, 0, 0, 0, 0),
      mk(KIND_VFILL, 31, 127, "y", 5, 0, 0, 0, 0),
      mk(KIND_PLOT,  31, 127, 8'hFF, 0, 0, 0, 0, 0),
      mk(KIND_READ,  31, 127, 0, 0, 0, 0, 0, 0, 1'b1, SpaceChar),
      mk(KIND_READ,  24, 79, 0, 0, 0, 0, 0, 0),
      mk(KIND_COPY,  0, 0, 0, 0, 2, 4, 0, 1),
      mk(KIND_MOVE,  0, 0, 0, 0, 3, 3, 1, 1),
      mk(KIND_COPY,  0, 0, 0, 0, 0, 10, 5, 5),
      mk(KIND_MOVE,  0, 0, 0, 0, 10, 0, 5, 5),
      mk(KIND_MOVE,  23, 78, 0, 0, 4, 4, 0, 0),
      mk(KIND_COPY,  0, 0, 0, 0, 31, 127, 2, 3),
      mk(KIND_COPY,  20, 70, 0, 0, 5, 10, 31, 127),
      mk(KIND_SPARE6, 31, 127, 8'hFF, 127, 31, 127, 31, 127, 1'b1, 0),
      mk(KIND_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0),
      mk(KIND_READ,  2, 3, 0, 0, 0, 0, 0, 0),
      mk(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 0),
      mk(KIND_READ,  24, 75, 0, 0, 0, 0, 0, 0)
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) cmd_queue.push_back(dir_tab[i]);
    drain();
    // fill the block while the receiver holds off
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) cmd_queue.push_back(mk(KIND_PLOT, i, i, "a" + i, 0, 0, 0, 0, 0));
    drain();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int i = 0; i < NumRandom / 4; i++) cmd_queue.push_back(rand_row());
      drain();
    end
    repeat (100) @(posedge clk_i);
    $display("Checked %0d result words over four idling phases and one backpressure stretch",
             words_done);
    $display("By kind: plot %0d hfill %0d vfill %0d copy %0d move %0d read %0d spare %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6] + kind_seen[7]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
